>>> src/e2rm_pkg.sv
// Package with the constants, types and CORDIC angle table of the Euler to rotation matrix core.
package e2rm_pkg;

  localparam int unsigned AngleW     = 16;
  localparam int unsigned TransW     = 32;
  localparam int unsigned EntryW     = 16;
  localparam int unsigned CordicN    = 18;
  localparam int unsigned CordicW    = 28;
  localparam int unsigned ZW         = 24;
  localparam int unsigned ProdW      = 45;
  localparam int unsigned InDataW    = 3 * AngleW + 3 * TransW;
  localparam int unsigned OutDataW   = 9 * EntryW + 3 * TransW;

  localparam logic signed [17:0] FullTurn    = 18'sd46080;
  localparam logic signed [17:0] HalfTurn    = 18'sd23040;
  localparam logic signed [17:0] QuarterTurn = 18'sd11520;
  localparam logic signed [CordicW-1:0] CordicGain = 28'sd10188014;
  localparam logic signed [EntryW-1:0]  Q14One     = 16'sd16384;

  localparam logic CONV_XYZ = 1'b0;
  localparam logic CONV_ZXZ = 1'b1;

  typedef logic signed [EntryW-1:0] q14_t;

  typedef struct packed {
    logic signed [CordicW-1:0] x;
    logic signed [CordicW-1:0] y;
    logic signed [ZW-1:0]      z;
    logic                      neg;
  } cordic_t;

  function automatic logic signed [ZW-1:0] atan_deg(input int unsigned i);
    logic signed [ZW-1:0] r;
    case (i)
      0: r = 24'sd1474560;  1: r = 24'sd870484;  2: r = 24'sd459940;
      3: r = 24'sd233473;   4: r = 24'sd117189;  5: r = 24'sd58652;
      6: r = 24'sd29333;    7: r = 24'sd14667;   8: r = 24'sd7334;
      9: r = 24'sd3667;     10: r = 24'sd1833;   11: r = 24'sd917;
      12: r = 24'sd458;     13: r = 24'sd229;    14: r = 24'sd115;
      15: r = 24'sd57;      16: r = 24'sd29;     default: r = 24'sd14;
    endcase
    return r;
  endfunction

endpackage

>>> src/euler_to_rotation_matrix_core.sv
// Top level of the Euler to rotation matrix core: pipelined CORDIC, products and rounding.
//
// Usage: an item enters on the s_axis group (s_axis_tvalid/tready/tdata) and carries three
// Euler angles in 1/128 degree plus a translation. The result item leaves on m_axis with
// the nine Q2.14 rotation entries and the translation copied unchanged. The convention
// register (0 = XYZ, 1 = ZXZ) is written over cfg_valid_i/cfg_ready_o/cfg_data_i and must
// only be changed while the pipeline is empty.
// Throughput is one item per cycle while m_axis is not stalled. The pipeline holds 25
// register stages: one wrap stage, eighteen CORDIC stages (one micro-rotation each, the
// three angles in parallel), one rounding stage, two multiplier stages for the three-way
// products, one summing stage, one final rounding stage and the output register.
// Every stage holds a valid bit; the whole pipeline advances only when the output
// register is empty or being taken, so a stalled receiver freezes every stage and
// nothing is lost or repeated. s_axis_tready follows the same advance signal.
// Reset clears all valid bits and the convention register; payload is not reset.
module euler_to_rotation_matrix_core import e2rm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // angle_first, angle_second, angle_third, trans_x, trans_y, trans_z
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22, out_x, out_y, out_z
  output logic [OutDataW-1:0] m_axis_tdata
);

  localparam int unsigned NStage = CordicN + 7;

  logic                conv_q;
  logic                adv;
  logic [NStage-1:0]   vld_q;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conv_q <= CONV_XYZ;
    end else if (cfg_valid_i) begin
      conv_q <= cfg_data_i;
    end
  end

  assign adv           = !vld_q[NStage-1] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld_q[NStage-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NStage-2:0], s_axis_tvalid};
    end
  end

  // Translation travels alongside in a delay line.
  logic [3*TransW-1:0] tr_q [NStage];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      tr_q[0] <= s_axis_tdata[InDataW-1:3*AngleW];
      for (int k = 1; k < NStage; k++) tr_q[k] <= tr_q[k-1];
    end
  end

  // Stage 0: wrap each angle to a quarter turn, noting a half-turn flip.
  cordic_t cs_q [3][CordicN+1];
  for (genvar a = 0; a < 3; a++) begin : g_wrap
    always_ff @(posedge clk_i) begin
      logic signed [17:0] v;
      logic               n;
      if (adv) begin
        v = 18'(signed'(s_axis_tdata[a*AngleW +: AngleW]));
        if (v > HalfTurn) v = v - FullTurn;
        if (v < -HalfTurn) v = v + FullTurn;
        n = 1'b0;
        if (v > QuarterTurn) begin
          v = v - HalfTurn; n = 1'b1;
        end else if (v < -QuarterTurn) begin
          v = v + HalfTurn; n = 1'b1;
        end
        cs_q[a][0].x   <= CordicGain;
        cs_q[a][0].y   <= '0;
        cs_q[a][0].z   <= {v[15:0], 8'd0};
        cs_q[a][0].neg <= n;
      end
    end
  end

  // Stages 1..18: one micro-rotation per stage.
  for (genvar i = 0; i < CordicN; i++) begin : g_cordic
    for (genvar a = 0; a < 3; a++) begin : g_axis
      always_ff @(posedge clk_i) begin
        if (adv) begin
          if (!cs_q[a][i].z[ZW-1]) begin
            cs_q[a][i+1].x <= cs_q[a][i].x - (cs_q[a][i].y >>> i);
            cs_q[a][i+1].y <= cs_q[a][i].y + (cs_q[a][i].x >>> i);
            cs_q[a][i+1].z <= cs_q[a][i].z - atan_deg(i);
          end else begin
            cs_q[a][i+1].x <= cs_q[a][i].x + (cs_q[a][i].y >>> i);
            cs_q[a][i+1].y <= cs_q[a][i].y - (cs_q[a][i].x >>> i);
            cs_q[a][i+1].z <= cs_q[a][i].z + atan_deg(i);
          end
          cs_q[a][i+1].neg <= cs_q[a][i].neg;
        end
      end
    end
  end

  function automatic q14_t rnd_sat(input logic signed [CordicW-1:0] v, input logic n);
    logic signed [CordicW-1:0] r;
    logic signed [EntryW:0]    s;
    r = (v + 28'sd512) >>> 10;
    if (r > 28'sd16384) s = 17'sd16384;
    else if (r < -28'sd16384) s = -17'sd16384;
    else s = r[EntryW:0];
    if (n) s = -s;
    return s[EntryW-1:0];
  endfunction

  // Round to Q2.14.
  q14_t s_q [3];
  q14_t c_q [3];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        s_q[a] <= rnd_sat(cs_q[a][CordicN].y, cs_q[a][CordicN].neg);
        c_q[a] <= rnd_sat(cs_q[a][CordicN].x, cs_q[a][CordicN].neg);
      end
    end
  end

  // Products stage 1: pairwise Q28 products, with third factor held.
  // Index per entry: p = a*b (Q28); three-way terms use t = p*c.
  logic signed [31:0] p_q [13];
  q14_t               f_q [4];
  logic               cv1_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      cv1_q <= conv_q;
      if (conv_q == CONV_XYZ) begin
        p_q[0]  <= c_q[1] * c_q[2];  p_q[1] <= c_q[1] * s_q[2];
        p_q[2]  <= 32'(s_q[1]) <<< 14;
        p_q[3]  <= s_q[0] * s_q[1];  p_q[4] <= c_q[0] * s_q[2];
        p_q[5]  <= c_q[0] * c_q[2];  p_q[6] <= s_q[0] * c_q[1];
        p_q[7]  <= c_q[0] * s_q[1];  p_q[8] <= s_q[0] * s_q[2];
        p_q[9]  <= s_q[0] * c_q[2];  p_q[10] <= c_q[0] * c_q[1];
        p_q[11] <= '0;               p_q[12] <= '0;
        f_q[0] <= c_q[2]; f_q[1] <= s_q[2]; f_q[2] <= c_q[2]; f_q[3] <= s_q[2];
      end else begin
        p_q[0]  <= s_q[0] * c_q[1];  p_q[1] <= c_q[0] * c_q[2];
        p_q[2]  <= c_q[0] * s_q[2];  p_q[3] <= s_q[0] * s_q[1];
        p_q[4]  <= c_q[0] * c_q[1];  p_q[5] <= s_q[0] * c_q[2];
        p_q[6]  <= s_q[0] * s_q[2];  p_q[7] <= c_q[0] * s_q[1];
        p_q[8]  <= s_q[1] * s_q[2];  p_q[9] <= s_q[1] * c_q[2];
        p_q[10] <= 32'(c_q[1]) <<< 14;
        p_q[11] <= '0;               p_q[12] <= '0;
        f_q[0] <= s_q[2]; f_q[1] <= c_q[2]; f_q[2] <= s_q[2]; f_q[3] <= c_q[2];
      end
    end
  end

  // Products stage 2: all terms in Q42.
  logic signed [ProdW-1:0] t_d [13];
  logic signed [ProdW-1:0] t_q [13];
  logic                    cv2_q;
  function automatic logic signed [ProdW-1:0] sc(input logic signed [31:0] p);
    return ProdW'(p) <<< 14;
  endfunction
  always_comb begin
    for (int k = 0; k < 13; k++) t_d[k] = sc(p_q[k]);
    if (cv1_q == CONV_XYZ) begin
      t_d[3]  = ProdW'(p_q[3]) * ProdW'(f_q[0]);   // s1 s2 c3
      t_d[11] = ProdW'(p_q[3]) * ProdW'(f_q[1]);   // s1 s2 s3
      t_d[7]  = ProdW'(p_q[7]) * ProdW'(f_q[2]);   // c1 s2 c3
      t_d[12] = ProdW'(p_q[7]) * ProdW'(f_q[3]);   // c1 s2 s3
    end else begin
      t_d[0]  = ProdW'(p_q[0]) * ProdW'(f_q[0]);   // s1 c2 s3
      t_d[11] = ProdW'(p_q[0]) * ProdW'(f_q[1]);   // s1 c2 c3
      t_d[4]  = ProdW'(p_q[4]) * ProdW'(f_q[2]);   // c1 c2 s3
      t_d[12] = ProdW'(p_q[4]) * ProdW'(f_q[3]);   // c1 c2 c3
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      cv2_q <= cv1_q;
      t_q   <= t_d;
    end
  end

  // Summing stage.
  logic signed [ProdW:0] m_q [9];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (cv2_q == CONV_XYZ) begin
        m_q[0] <= 46'(t_q[0]);
        m_q[1] <= -46'(t_q[1]);
        m_q[2] <= 46'(t_q[2]);
        m_q[3] <= 46'(t_q[3]) + 46'(t_q[4]);
        m_q[4] <= 46'(t_q[5]) - 46'(t_q[11]);
        m_q[5] <= -46'(t_q[6]);
        m_q[6] <= 46'(t_q[8]) - 46'(t_q[7]);
        m_q[7] <= 46'(t_q[12]) + 46'(t_q[9]);
        m_q[8] <= 46'(t_q[10]);
      end else begin
        m_q[0] <= 46'(t_q[1]) - 46'(t_q[0]);
        m_q[1] <= -46'(t_q[11]) - 46'(t_q[2]);
        m_q[2] <= 46'(t_q[3]);
        m_q[3] <= 46'(t_q[4]) + 46'(t_q[5]);
        m_q[4] <= 46'(t_q[12]) - 46'(t_q[6]);
        m_q[5] <= -46'(t_q[7]);
        m_q[6] <= 46'(t_q[8]);
        m_q[7] <= 46'(t_q[9]);
        m_q[8] <= 46'(t_q[10]);
      end
    end
  end

  // Final rounding to Q2.14 and output register.
  q14_t e_q [9];
  logic [OutDataW-1:0] out_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 9; k++) begin
        logic signed [ProdW:0] r;
        r = (m_q[k] + (46'sd1 <<< 27)) >>> 28;
        if (r > 46'sd16384) e_q[k] <= Q14One;
        else if (r < -46'sd16384) e_q[k] <= -Q14One;
        else e_q[k] <= r[EntryW-1:0];
      end
      out_q <= {tr_q[NStage-2], e_q[8], e_q[7], e_q[6], e_q[5], e_q[4], e_q[3],
                e_q[2], e_q[1], e_q[0]};
    end
  end

  assign m_axis_tdata = out_q;

endmodule
